FILE: design/assert_macros.svh
// assertion macros shared by the nth-root block
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check of a property on the rising clock edge, off during reset
`define NRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define NRB_ASSERT_IMP(label, ante, cons, msg) \
  `NRB_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define NRB_ASSERT_NXT(label, ante, cons, msg) \
  `NRB_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: design/nrb_pkg.sv
// shared types and constants of the nth-root bisection block
// no dependencies; used by nrb_pow and nth_root_bisection_top
`timescale 1ns / 1ps

package nrb_pkg;

  // fixed-point value format
  localparam int FracBits = 16;
  localparam int IntBits  = 16;
  localparam int ValBits  = IntBits + FracBits;

  typedef logic [ValBits-1:0] val_t;

  localparam val_t One     = val_t'(1) << FracBits;
  localparam val_t ValMask = '1;

  // round guard and default degree limit
  localparam int MaxRounds     = 2 * ValBits + 8;
  localparam int RoundW        = $clog2(MaxRounds);
  localparam int DefMaxExponent = 16;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POW,
    ST_UPDATE,
    ST_CHECK
  } nrb_state_e;

  // control from the sequencer to the power unit
  typedef struct packed {
    logic load;
    logic step;
  } pow_ctrl_t;

endpackage

FILE: design/nrb_pow.sv
// shared power unit: one saturating fixed-point multiply per step into an accumulator
// depends on nrb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nrb_pow (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nrb_pkg::pow_ctrl_t ctrl_i,
  input  nrb_pkg::val_t     guess_i,
  output nrb_pkg::val_t     pow_o,
  output logic              sat_o
);

  localparam int VW = nrb_pkg::ValBits;
  localparam int FB = nrb_pkg::FracBits;

  nrb_pkg::val_t   pow_q, pow_d;
  logic            sat_q, sat_d;
  logic [2*VW-1:0] prod;
  logic            ovf;

  // full-width product and overflow of the shifted result
  assign prod = (2*VW)'(pow_q) * (2*VW)'(guess_i);
  assign ovf  = |prod[2*VW-1:VW+FB];

  // accumulator update, held once saturated
  always_comb begin
    pow_d = pow_q;
    sat_d = sat_q;
    if (ctrl_i.load) begin
      pow_d = nrb_pkg::One;
      sat_d = 1'b0;
    end else if (ctrl_i.step && !sat_q) begin
      if (ovf) begin
        pow_d = nrb_pkg::ValMask;
        sat_d = 1'b1;
      end else begin
        pow_d = prod[VW+FB-1:FB];
      end
    end
  end

  // saturation flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else begin
      sat_q <= sat_d;
    end
  end

  // accumulator
  always_ff @(posedge clk_i) begin
    pow_q <= pow_d;
  end

  assign pow_o = pow_q;
  assign sat_o = sat_q;

  `NRB_ASSERT_IMP(a_sat_holds_max, sat_q, pow_q == nrb_pkg::ValMask, "saturated power not at max")
  `NRB_ASSERT_NXT(a_load_clears, ctrl_i.load, !sat_q && pow_q == nrb_pkg::One, "load did not set 1.0")
  `NRB_ASSERT_NXT(a_sat_sticky, sat_q && !ctrl_i.load, sat_q, "saturation dropped without load")

endmodule

FILE: design/nth_root_bisection_top.sv
// nth-root by bisection: sequencer, bounds and tolerance register around the power unit
// depends on nrb_pkg, nrb_pow and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel   ports                               direction  handshake
//  request   start, radicand_i, exponent_i       in         start & !busy
//  result    done_o, root_o                      out        done_o, one cycle
//  config    cfg_valid_i, cfg_data_i, cfg_ready_o in        cfg_valid_i & cfg_ready_o
//
//  A request runs R rounds after the accepting edge, then the result strobe;
//  m = min(n, MAX_EXPONENT), R rounds (at most 72, about 33 for a tight tolerance): each
//  round runs m steps of the shared multiplier, one per cycle, then sees the count
//  complete, moves the bounds and tests the change.
//  busy is high from the cycle after acceptance until the result strobe.
//  Reset puts the sequencer idle and the tolerance to one LSB; no clearing pass.
//  The result cannot be held off; the next request may start in the strobe cycle.
module nth_root_bisection_top #(
  parameter int MAX_EXPONENT = nrb_pkg::DefMaxExponent
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] radicand_i,
  input  logic [4:0]  exponent_i,
  output logic        done_o,
  output logic [31:0] root_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int ExpW = $clog2(MAX_EXPONENT + 1);
  localparam int RW   = nrb_pkg::RoundW;

  nrb_pkg::nrb_state_e state_q, state_d;
  nrb_pkg::pow_ctrl_t  pow_ctrl;
  nrb_pkg::val_t       x_q, lo_q, hi_q, guess_q, mid_q, root_q;
  nrb_pkg::val_t       pow, lo_n, hi_n, mid_n, hi_init, change;
  logic [31:0]         tol_q;
  logic [ExpW-1:0]     n_q, n_in, cnt_q;
  logic [RW-1:0]       round_q;
  logic                pow_sat, less, stop, accept, done_q;

  // shared power unit
  nrb_pow u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pow_ctrl),
    .guess_i (guess_q),
    .pow_o   (pow),
    .sat_o   (pow_sat)
  );

  assign accept = start && (state_q == nrb_pkg::ST_IDLE);

  // clamp the degree
  always_comb begin
    if (32'(exponent_i) > 32'(MAX_EXPONENT)) begin
      n_in = ExpW'(MAX_EXPONENT);
    end else begin
      n_in = ExpW'(exponent_i);
    end
  end

  // upper bound is max(1.0, x)
  assign hi_init = (nrb_pkg::val_t'(radicand_i) < nrb_pkg::One) ?
                   nrb_pkg::One : nrb_pkg::val_t'(radicand_i);

  // bound move and new midpoint
  assign less  = !pow_sat && (pow < x_q);
  assign lo_n  = less ? guess_q : lo_q;
  assign hi_n  = less ? hi_q : guess_q;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

  // stop test on the guess change
  assign change = (mid_q >= guess_q) ? (mid_q - guess_q) : (guess_q - mid_q);
  assign stop   = (32'(change) <= tol_q) || (round_q == RW'(nrb_pkg::MaxRounds - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nrb_pkg::ST_IDLE: begin
        if (start) state_d = nrb_pkg::ST_POW;
      end
      nrb_pkg::ST_POW: begin
        if (cnt_q == n_q) state_d = nrb_pkg::ST_UPDATE;
      end
      nrb_pkg::ST_UPDATE: begin
        state_d = nrb_pkg::ST_CHECK;
      end
      nrb_pkg::ST_CHECK: begin
        state_d = stop ? nrb_pkg::ST_IDLE : nrb_pkg::ST_POW;
      end
      default: state_d = nrb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pow_ctrl = '0;
    unique case (state_q)
      nrb_pkg::ST_IDLE:   pow_ctrl.load = start;
      nrb_pkg::ST_POW:    pow_ctrl.step = (cnt_q != n_q);
      nrb_pkg::ST_UPDATE: pow_ctrl = '0;
      nrb_pkg::ST_CHECK:  pow_ctrl.load = !stop;
      default:            pow_ctrl = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrb_pkg::ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      round_q <= '0;
      tol_q   <= 32'd1;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == nrb_pkg::ST_CHECK) && stop;
      if (cfg_valid_i && cfg_ready_o) tol_q <= cfg_data_i;
      if (accept) begin
        cnt_q   <= '0;
        round_q <= '0;
      end else if (pow_ctrl.step) begin
        cnt_q <= cnt_q + 1'b1;
      end else if ((state_q == nrb_pkg::ST_CHECK) && !stop) begin
        cnt_q   <= '0;
        round_q <= round_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= nrb_pkg::val_t'(radicand_i);
      n_q     <= n_in;
      lo_q    <= '0;
      hi_q    <= hi_init;
      guess_q <= hi_init >> 1;
    end
    if (state_q == nrb_pkg::ST_UPDATE) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
    if (state_q == nrb_pkg::ST_CHECK) begin
      if (stop) root_q <= mid_q;
      else      guess_q <= mid_q;
    end
  end

  assign busy        = (state_q != nrb_pkg::ST_IDLE);
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign root_o      = 32'(root_q);

  `NRB_ASSERT_IMP(a_done_idle, done_q, state_q == nrb_pkg::ST_IDLE, "strobe while busy")
  `NRB_ASSERT_NXT(a_check_stop, state_q == nrb_pkg::ST_CHECK && stop, done_q, "missing strobe")
  `NRB_ASSERT_IMP(a_mid_in_bounds, state_q == nrb_pkg::ST_CHECK,
                  mid_q >= lo_q && mid_q <= hi_q, "midpoint outside bounds")

endmodule
